FILE: hw/rtl/priority_ordered_entry_table_core_macros.svh
// Assertion helpers for the entry table core
`ifndef PRIORITY_ORDERED_ENTRY_TABLE_CORE_MACROS_SVH
`define PRIORITY_ORDERED_ENTRY_TABLE_CORE_MACROS_SVH

// property holds on every clock edge outside reset
`define POET_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge, reset included
`define POET_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/poet_pkg.sv
`default_nettype none
package poet_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_FIND    = 3'd2,
        OP_NEXT    = 3'd3,
        OP_REPRI   = 3'd4,
        OP_SETST   = 3'd5,
        OP_SETRS   = 3'd6,
        OP_CLEAR   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_NOTFOUND = 2'd1,
        ERR_FULL     = 2'd2
    } t_err;

    localparam logic [1:0] ST_STOPPED = 2'd0;
    localparam logic [1:0] ST_PLAYING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] entry_handle;
        logic signed [7:0] entry_priority;
        logic [1:0]  new_status;
        logic        restore_mode;
        logic        from_start;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [1:0]  error_code;
        logic [31:0] found_handle;
        logic signed [7:0] found_priority;
        logic [1:0]  found_status;
        logic        found_restore;
        logic [4:0]  entry_count;
    } t_out_word;

    typedef struct packed {
        logic [31:0] handle;
        logic signed [7:0] priority_val;
        logic [1:0]  status;
        logic        restore;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_DISPATCH, S_SCAN, S_SHIFT_OUT, S_FIND_POS,
        S_SHIFT_IN, S_WRITE, S_RESP, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input word
        logic clr_idx;     // idx <= 0
        logic inc_idx;     // idx <= idx + 1
        logic set_idx_pos; // not used by the datapath
        logic set_idx_cnt; // idx <= count
        logic dec_idx;
        logic shift_down;  // slot[idx] <= slot[idx+1]
        logic shift_up;    // slot[idx] <= slot[idx-1]
        logic dec_count;
        logic inc_count;
        logic clr_count;
        logic write_new;   // slot[marked position] <= new entry
        logic write_st;
        logic write_rs;
        logic hold_entry;  // pending <= slot[idx]
        logic mark_found;  // remember position idx
        logic rep_idx;     // result <= slot[idx]
        logic rep_none;
        logic [1:0] err;
        logic out_valid_set;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic from_start;
        logic idx_lt_cnt;     // idx < count (idx > marked position while shifting in)
        logic idx_last;       // idx + 1 >= count
        logic idx_zero;
        logic handle_eq;      // slot[idx].handle == request handle
        logic active;         // slot[idx] playing or waiting
        logic pri_gt;         // slot[idx].priority > request priority
        logic pri_lower;      // reference priority > slot[idx].priority
        logic full;
        logic out_busy;
    } t_sts;

endpackage
`default_nettype wire

FILE: hw/rtl/poet_if.sv
`default_nettype none
interface poet_in_if;
    import poet_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/poet_out_if.sv
`default_nettype none
interface poet_out_if;
    import poet_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/poet_ctrl.sv
`default_nettype none
module poet_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire poet_pkg::t_sts i_sts,
    output poet_pkg::t_cmd      o_cmd,
    output poet_pkg::t_state    o_state
);
    import poet_pkg::*;

    t_state r_state, n_state;
    logic   r_after;   // next active: search after a named entry
    logic   n_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

    assign o_state    = r_state;
    assign o_in_ready = (r_state == S_IDLE) && !i_sts.out_busy;

    // next state
    always_comb begin
        n_state = r_state;
        n_after = r_after;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.op)
                    OP_CLEAR: n_state = S_OUT;
                    OP_ADD:   n_state = i_sts.full ? S_OUT : S_FIND_POS;
                    OP_NEXT: begin
                        n_after = !i_sts.from_start;
                        n_state = i_sts.from_start ? S_SCAN : S_LOOK;
                    end
                    default:  n_state = S_LOOK;
                endcase
            end
            S_LOOK: begin
                if (!i_sts.idx_lt_cnt) begin
                    n_state = S_OUT;
                end else if (i_sts.handle_eq) begin
                    unique case (i_sts.op)
                        OP_REMOVE, OP_REPRI: n_state = S_SHIFT_OUT;
                        OP_NEXT:             n_state = S_SCAN;
                        default:             n_state = S_OUT;
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_sts.idx_lt_cnt || i_sts.active) begin
                    n_state = S_OUT;
                end
            end
            S_SHIFT_OUT: begin
                if (i_sts.idx_last) begin
                    n_state = (i_sts.op == OP_REPRI) ? S_FIND_POS : S_OUT;
                end
            end
            S_FIND_POS: begin
                if (!i_sts.idx_lt_cnt || !i_sts.pri_gt) begin
                    n_state = S_SHIFT_IN;
                end
            end
            S_SHIFT_IN: begin
                if (i_sts.idx_zero || !i_sts.idx_lt_cnt) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE:  n_state = S_OUT;
            S_RESP:   n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.err = ERR_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op == OP_CLEAR) begin
                    o_cmd.clr_count = 1'b1;
                    o_cmd.rep_none  = 1'b1;
                end else if (i_sts.op == OP_ADD && i_sts.full) begin
                    o_cmd.rep_none = 1'b1;
                    o_cmd.err      = ERR_FULL;
                end
            end
            S_LOOK: begin
                if (!i_sts.idx_lt_cnt) begin
                    o_cmd.rep_none = 1'b1;
                    o_cmd.err      = ERR_NOTFOUND;
                end else if (i_sts.handle_eq) begin
                    o_cmd.mark_found = 1'b1;
                    o_cmd.hold_entry = 1'b1;
                    unique case (i_sts.op)
                        OP_REMOVE: o_cmd.rep_idx = 1'b1;
                        OP_NEXT:   o_cmd.inc_idx = 1'b1;
                        OP_SETST: begin
                            o_cmd.write_st = 1'b1;
                            o_cmd.rep_idx  = 1'b1;
                        end
                        OP_SETRS: begin
                            o_cmd.write_rs = 1'b1;
                            o_cmd.rep_idx  = 1'b1;
                        end
                        OP_FIND:  o_cmd.rep_idx = 1'b1;
                        default: ;
                    endcase
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SCAN: begin
                if (!i_sts.idx_lt_cnt) begin
                    o_cmd.rep_none = 1'b1;
                end else if (i_sts.active) begin
                    if (r_after && i_sts.pri_lower) o_cmd.rep_none = 1'b1;
                    else                            o_cmd.rep_idx  = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SHIFT_OUT: begin
                if (i_sts.idx_last) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.clr_idx   = 1'b1;
                end else begin
                    o_cmd.shift_down = 1'b1;
                    o_cmd.inc_idx    = 1'b1;
                end
            end
            S_FIND_POS: begin
                if (!i_sts.idx_lt_cnt || !i_sts.pri_gt) begin
                    o_cmd.mark_found  = 1'b1;
                    o_cmd.set_idx_cnt = 1'b1;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_SHIFT_IN: begin
                // idx walks down from count to the insert point
                if (!(i_sts.idx_zero || !i_sts.idx_lt_cnt)) begin
                    o_cmd.shift_up = 1'b1;
                    o_cmd.dec_idx  = 1'b1;
                end
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                o_cmd.inc_count = 1'b1;
            end
            S_OUT: o_cmd.out_valid_set = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/poet_dp.sv
`default_nettype none
module poet_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire poet_pkg::t_in_word i_word,
    input  wire poet_pkg::t_cmd    i_cmd,
    input  wire poet_pkg::t_state  i_state,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output poet_pkg::t_out_word    o_word,
    output poet_pkg::t_sts         o_sts
);
    import poet_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_entry        r_slot [MAX_ENTRIES];
    t_in_word      r_req;
    t_entry        r_pend;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pos;
    logic signed [7:0] r_ref_pri;
    logic          r_out_valid;
    t_out_word     r_out;

    logic [IW-1:0] w_ix;
    logic [IW-1:0] w_ixp;
    logic [IW-1:0] w_ixm;
    t_entry        w_cur;
    t_entry        w_new;
    logic          w_write_new_q;

    assign w_ix  = r_idx[IW-1:0];
    assign w_ixp = w_ix + IW'(1);
    assign w_ixm = w_ix - IW'(1);
    assign w_cur = r_slot[w_ix];

    // entry written at the insert point
    always_comb begin
        w_new.handle       = r_req.entry_handle;
        w_new.priority_val = r_req.entry_priority;
        if (t_op'(r_req.operation) == OP_REPRI) begin
            w_new.status  = r_pend.status;
            w_new.restore = r_pend.restore;
        end else begin
            w_new.status  = ST_STOPPED;
            w_new.restore = 1'b0;
        end
    end
    assign w_write_new_q = i_cmd.write_new;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_word;
        if (i_cmd.hold_entry) begin
            r_pend    <= w_cur;
            r_ref_pri <= w_cur.priority_val;
        end
        if (i_cmd.shift_down) r_slot[w_ix] <= r_slot[w_ixp];
        if (i_cmd.shift_up)   r_slot[w_ix] <= r_slot[w_ixm];
        if (w_write_new_q)    r_slot[r_pos[IW-1:0]] <= w_new;
        if (i_cmd.write_st)   r_slot[w_ix].status  <= r_req.new_status;
        if (i_cmd.write_rs)   r_slot[w_ix].restore <= r_req.restore_mode;
        if (i_cmd.mark_found) r_pos <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_idx)          r_idx <= '0;
            else if (i_cmd.inc_idx)     r_idx <= r_idx + CW'(1);
            else if (i_cmd.dec_idx)     r_idx <= r_idx - CW'(1);
            else if (i_cmd.set_idx_cnt) r_idx <= r_cnt;
            if (i_cmd.clr_count)      r_cnt <= '0;
            else if (i_cmd.dec_count) r_cnt <= r_cnt - CW'(1);
            else if (i_cmd.inc_count) r_cnt <= r_cnt + CW'(1);
            if (i_cmd.out_valid_set)               r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)   r_out_valid <= 1'b0;
        end
    end

    // result register; count field filled at presentation
    always_ff @(posedge i_clk) begin
        if (i_cmd.rep_none) begin
            r_out <= '0;
            r_out.error_code <= i_cmd.err;
        end else if (i_cmd.rep_idx) begin
            r_out.hit            <= 1'b1;
            r_out.error_code     <= ERR_OK;
            r_out.found_handle   <= w_cur.handle;
            r_out.found_priority <= w_cur.priority_val;
            r_out.found_status   <= i_cmd.write_st ? r_req.new_status : w_cur.status;
            r_out.found_restore  <= i_cmd.write_rs ? r_req.restore_mode : w_cur.restore;
        end else if (w_write_new_q) begin
            r_out.hit            <= 1'b1;
            r_out.error_code     <= ERR_OK;
            r_out.found_handle   <= w_new.handle;
            r_out.found_priority <= w_new.priority_val;
            r_out.found_status   <= w_new.status;
            r_out.found_restore  <= w_new.restore;
        end
    end

    always_comb begin
        o_word             = r_out;
        o_word.entry_count = 5'(r_cnt);
    end
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts            = '0;
        o_sts.op         = t_op'(r_req.operation);
        o_sts.from_start = r_req.from_start;
        o_sts.idx_lt_cnt = r_idx < r_cnt;
        o_sts.idx_last   = (r_idx + CW'(1)) >= r_cnt;
        o_sts.idx_zero   = (r_idx == '0) || (r_idx == r_pos);
        o_sts.handle_eq  = w_cur.handle == r_req.entry_handle;
        o_sts.active     = (w_cur.status == ST_WAITING) || (w_cur.status == ST_PLAYING);
        o_sts.pri_gt     = w_cur.priority_val > r_req.entry_priority;
        o_sts.pri_lower  = r_ref_pri > w_cur.priority_val;
        o_sts.full       = r_cnt == CW'(MAX_ENTRIES);
        o_sts.out_busy   = r_out_valid || (i_state == S_OUT);
        if (i_state == S_SHIFT_IN) o_sts.idx_lt_cnt = r_idx > r_pos;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/priority_ordered_entry_table_core.sv
`default_nettype none
// Priority-sorted table of up to MAX_ENTRIES entries (handle, priority, status,
// restore mode), head first, newest ahead of equal priority. One word in gives
// one word out carrying the entry count. Items are handled one at a time: a
// controller walks one slot per cycle through lookup, scan and shift loops; a
// reprioritise takes the entry out, then makes room for it. The result sits in
// an output register; the next word is taken once it has left.
`include "priority_ordered_entry_table_core_macros.svh"
module priority_ordered_entry_table_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    poet_in_if.sink   i_req,
    poet_out_if.source o_rsp
);
    import poet_pkg::*;

    t_cmd   w_cmd;
    t_sts   w_sts;
    t_state w_state;
    logic   w_in_ready;

    poet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    poet_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_req.data),
        .i_cmd       (w_cmd),
        .i_state     (w_state),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_word      (o_rsp.data),
        .o_sts       (w_sts)
    );

    assign i_req.ready = w_in_ready;

    // a word is only taken while idle with the result register empty
    `POET_ASSERT(a_accept_idle, i_clk, i_rst_n, (i_req.valid && i_req.ready) |-> (w_state == S_IDLE && !o_rsp.valid), "word accepted while busy")
    // count never exceeds the table size
    `POET_ASSERT(a_count_max, i_clk, i_rst_n, o_rsp.valid |-> (o_rsp.data.entry_count <= 5'(MAX_ENTRIES)), "entry count beyond table size")
    // a result always follows the closing state
    `POET_ASSERT(a_out_follows, i_clk, i_rst_n, (w_state == S_OUT) |=> o_rsp.valid, "result not raised")
    // hit results never carry an error
    `POET_ASSERT(a_hit_ok, i_clk, i_rst_n, (o_rsp.valid && o_rsp.data.hit) |-> (o_rsp.data.error_code == ERR_OK), "hit with error")
endmodule
`default_nettype wire

FILE: tb/poet_tb_pkg.sv
`timescale 1ns / 1ps
package poet_tb_pkg;
    import poet_pkg::*;

    localparam int TABLE_DEPTH = 16;

    class entry_table_scoreboard;
        t_entry     slots[TABLE_DEPTH];
        int         used;
        t_out_word  pending_rsp[$];
        int         mismatches;

        function new();
            used = 0;
            mismatches = 0;
        endfunction

        function int lookup(logic [31:0] h);
            for (int i = 0; i < used; i++)
                if (slots[i].handle == h) return i;
            return -1;
        endfunction

        function void take_out(int pos);
            for (int i = pos; i + 1 < used; i++) slots[i] = slots[i + 1];
            used--;
        endfunction

        function int put_in(t_entry e);
            int pos;
            pos = 0;
            while (pos < used && slots[pos].priority_val > e.priority_val) pos++;
            for (int i = used; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = e;
            used++;
            return pos;
        endfunction

        function void report_slot(ref t_out_word r, input int i);
            r.hit            = 1'b1;
            r.found_handle   = slots[i].handle;
            r.found_priority = slots[i].priority_val;
            r.found_status   = slots[i].status;
            r.found_restore  = slots[i].restore;
        endfunction

        // note an accepted request and queue the word it must produce
        function void note_request(t_in_word w);
            t_out_word r;
            t_entry    e;
            int        pos;
            int        i;
            int        start;
            r = '0;
            case (t_op'(w.operation))
                OP_ADD: begin
                    if (used >= TABLE_DEPTH) begin
                        r.error_code = ERR_FULL;
                    end else begin
                        e = '{w.entry_handle, w.entry_priority, ST_STOPPED, 1'b0};
                        report_slot(r, put_in(e));
                    end
                end
                OP_REMOVE, OP_FIND, OP_REPRI, OP_SETST, OP_SETRS: begin
                    pos = lookup(w.entry_handle);
                    if (pos < 0) begin
                        r.error_code = ERR_NOTFOUND;
                    end else if (t_op'(w.operation) == OP_REMOVE) begin
                        report_slot(r, pos);
                        take_out(pos);
                    end else if (t_op'(w.operation) == OP_FIND) begin
                        report_slot(r, pos);
                    end else if (t_op'(w.operation) == OP_REPRI) begin
                        e = slots[pos];
                        e.priority_val = w.entry_priority;
                        take_out(pos);
                        report_slot(r, put_in(e));
                    end else if (t_op'(w.operation) == OP_SETST) begin
                        slots[pos].status = w.new_status;
                        report_slot(r, pos);
                    end else begin
                        slots[pos].restore = w.restore_mode;
                        report_slot(r, pos);
                    end
                end
                OP_NEXT: begin
                    start = 0;
                    pos = -1;
                    if (!w.from_start) begin
                        pos = lookup(w.entry_handle);
                        if (pos < 0) r.error_code = ERR_NOTFOUND;
                        start = pos + 1;
                    end
                    if (w.from_start || pos >= 0) begin
                        for (i = start; i < used; i++)
                            if (slots[i].status == ST_WAITING
                                || slots[i].status == ST_PLAYING) break;
                        if (i < used && !(pos >= 0
                                && slots[pos].priority_val > slots[i].priority_val))
                            report_slot(r, i);
                    end
                end
                default: used = 0;
            endcase
            r.entry_count = 5'(used);
            pending_rsp.push_back(r);
        endfunction

        function void check_response(t_out_word got);
            t_out_word exp;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response word %h", got);
                return;
            end
            exp = pending_rsp.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %h got %h", exp, got);
            end
        endfunction
    endclass
endpackage

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import poet_pkg::*;
    import poet_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    poet_in_if  req_if ();
    poet_out_if rsp_if ();

    priority_ordered_entry_table_core #(.MAX_ENTRIES(TABLE_DEPTH)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    entry_table_scoreboard sb = new();
    logic [31:0] handle_pool[8];   // small pool so lookups mostly hit
    bit          stim_done = 0;
    int          cycles = 0;

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
    end

    // hard stop, set well beyond the worst-case run of all words and gaps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("priority_ordered_entry_table_core verification failed");
            $finish;
        end
    end

    // response side: random stall per word, check on the accepting edge
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            repeat (gap) @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            sb.check_response(rsp_if.data);
            @(negedge i_clk);
            rsp_if.ready <= 1'b0;
        end
    end

    // valid stays up after an accepted word until the next falling edge decides
    task automatic send_word(t_in_word w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.data  <= w;
        req_if.valid <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(w);
    endtask

    task automatic send_op(t_op op, logic [31:0] h, logic [7:0] p,
                           logic [1:0] st, logic rs, logic fs);
        t_in_word w;
        w = '{op, h, p, st, rs, fs};
        send_word(w);
    endtask

    task automatic send_random(bit fill_bias);
        t_in_word w;
        int r;
        w.entry_handle   = ($urandom_range(0, 9) == 0) ? $urandom()
                           : handle_pool[$urandom_range(0, 7)];
        w.entry_priority = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 255))
                           : 8'($urandom_range(0, 4) - 2);
        w.new_status     = 2'($urandom_range(0, 3));
        w.restore_mode   = 1'($urandom_range(0, 1));
        w.from_start     = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        // keep the table busy, with the odd clear so it also empties
        if (r < (fill_bias ? 45 : 20))  w.operation = OP_ADD;
        else if (r < 98)                w.operation = 3'($urandom_range(1, 6));
        else                            w.operation = OP_CLEAR;
        send_word(w);
    endtask

    initial begin
        for (int i = 0; i < 8; i++) handle_pool[i] = $urandom();
        handle_pool[0] = 32'h0;
        handle_pool[1] = 32'hFFFF_FFFF;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, ties, full, clear
        send_op(OP_FIND,   32'h0, 8'h0, 2'd0, 1'b0, 1'b0);
        send_op(OP_NEXT,   32'h0, 8'h0, 2'd0, 1'b0, 1'b1);
        send_op(OP_ADD,    32'hFFFF_FFFF, 8'h7F, 2'd0, 1'b0, 1'b0);
        send_op(OP_ADD,    32'h0, 8'h80, 2'd0, 1'b0, 1'b0);
        send_op(OP_ADD,    32'h5, 8'h7F, 2'd0, 1'b0, 1'b0);   // ahead of equal
        send_op(OP_SETST,  32'h0, 8'h0, 2'd3, 1'b0, 1'b0);
        send_op(OP_SETST,  32'h5, 8'h0, 2'd1, 1'b0, 1'b0);
        send_op(OP_SETRS,  32'h5, 8'h0, 2'd0, 1'b1, 1'b0);
        send_op(OP_NEXT,   32'h0, 8'h0, 2'd0, 1'b0, 1'b1);
        send_op(OP_NEXT,   32'h5, 8'h0, 2'd0, 1'b0, 1'b0);    // lower priority found
        send_op(OP_NEXT,   32'h1234, 8'h0, 2'd0, 1'b0, 1'b0); // absent anchor
        send_op(OP_REPRI,  32'h0, 8'h7F, 2'd0, 1'b0, 1'b0);
        send_op(OP_REPRI,  32'h1234, 8'h7F, 2'd0, 1'b0, 1'b0);
        send_op(OP_SETST,  32'h1234, 8'h0, 2'd2, 1'b0, 1'b0);
        send_op(OP_SETRS,  32'h1234, 8'h0, 2'd0, 1'b1, 1'b0);
        send_op(OP_REMOVE, 32'h5, 8'h0, 2'd0, 1'b0, 1'b0);
        send_op(OP_REMOVE, 32'h5, 8'h0, 2'd0, 1'b0, 1'b0);
        for (int i = 0; i < 15; i++)
            send_op(OP_ADD, 32'(i), 8'(i * 17), 2'd0, 1'b0, 1'b0);
        send_op(OP_ADD,    32'hAA, 8'h0, 2'd0, 1'b0, 1'b0);   // full
        send_op(OP_CLEAR,  32'h0, 8'h0, 2'd0, 1'b0, 1'b0);

        for (int i = 0; i < 1450; i++) send_random((i / 200) % 2 == 0);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("priority_ordered_entry_table_core verification clean");
        else
            $display("priority_ordered_entry_table_core verification failed");
        $finish;
    end
endmodule

FILE: priority_ordered_entry_table_core.f
+incdir+hw/rtl
hw/rtl/poet_pkg.sv
hw/rtl/poet_if.sv
hw/rtl/poet_out_if.sv
hw/rtl/poet_ctrl.sv
hw/rtl/poet_dp.sv
hw/rtl/priority_ordered_entry_table_core.sv
tb/poet_tb_pkg.sv
tb/tb.sv
